>>> sv/assert_macros.svh
// Assertion macros used by the slot pool sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk_s, rstn_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) else $error(msg);

`endif

>>> sv/spfl_pkg.sv
// Shared types, constants and helpers for the slot pool allocator.
package spfl_pkg;

    localparam int SLOT_COUNT = 32;
    localparam int SLOT_W     = 5;
    localparam int LINK_W     = 6;
    localparam int CNT_W      = 6;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [LINK_W-1:0] link_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    localparam link_t NULL_LINK  = LINK_W'(SLOT_COUNT);
    localparam cnt_t  FULL_COUNT = CNT_W'(SLOT_COUNT);
    localparam cnt_t  LAST_STEP  = CNT_W'(SLOT_COUNT - 1);

    typedef enum logic [1:0] {
        FUNC_ALLOC = 2'd0,
        FUNC_FREE  = 2'd1,
        FUNC_LIST  = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_EXHAUSTED  = 2'd1,
        STAT_NOT_ACTIVE = 2'd2,
        STAT_EMPTY      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_REPORT,
        ST_ALLOC_POP,
        ST_FREE_WALK,
        ST_FREE_UNLINK,
        ST_FREE_PUSH,
        ST_LIST
    } state_t;

    // Link table port request: one write and one read per cycle.
    typedef struct packed {
        logic  wr_en;
        slot_t wr_addr;
        link_t wr_data;
        logic  rd_en;
        slot_t rd_addr;
    } ram_req_t;

    // One result word handed to the output register.
    typedef struct packed {
        logic    valid;
        slot_t   slot_id;
        status_t status;
        logic    last;
    } emit_t;

    // Power-up link of an entry: next slot, last entry points to null.
    function automatic link_t init_link(slot_t addr);
        link_t lnk;
        lnk = {1'b0, addr} + link_t'(1);
        if (lnk == NULL_LINK)
            return NULL_LINK;
        return lnk;
    endfunction

endpackage

>>> sv/slot_pool_free_list_allocator.sv
// Allocate: dispatch reads the free head's link, then pop issues the slot. Free: dispatch,
// an active-list walk from the head, unlink, then push issues the slot; a miss reports.
// List: dispatch reads the head's link, then each active slot is issued. One request at
// a time, the next after the last word; one link read per cycle unless output stalls.
// Reset clears list heads and count; the link table reads as order 0..N-1
// until each entry is first written, so no clearing pass is needed.
module slot_pool_free_list_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [4:0]  slot_number,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  slot_id,
    output logic [1:0]  status,
    output logic        last
);

    spfl_pkg::ram_req_t ram_req;
    spfl_pkg::link_t    rd_data;
    spfl_pkg::emit_t    emit;
    logic               out_free;

    logic               out_valid_reg;
    spfl_pkg::slot_t    slot_id_reg;
    logic [1:0]         status_reg;
    logic               last_reg;

    // The output register can take a word when empty or draining this cycle.
    assign out_free = !out_valid_reg || !out_stall;

    // Sequencer: decodes the request, walks the lists, builds result words.
    spfl_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .func        (func),
        .slot_number (slot_number),
        .in_stall    (in_stall),
        .out_free    (out_free),
        .emit        (emit),
        .ram_req     (ram_req),
        .rd_data     (rd_data)
    );

    // Link table shared by the free and active lists.
    spfl_link_ram u_link_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    // Output word register: decouples the sequencer from downstream stall.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit.valid)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            slot_id_reg <= emit.slot_id;
            status_reg  <= emit.status;
            last_reg    <= emit.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign slot_id   = slot_id_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule

>>> sv/spfl_link_ram.sv
// Link table memory with per-entry written flags and registered read.
module spfl_link_ram (
    input  logic                clk,
    input  logic                rst_n,
    input  spfl_pkg::ram_req_t  req,
    output spfl_pkg::link_t     rd_data
);

    spfl_pkg::link_t                      mem [spfl_pkg::SLOT_COUNT];
    logic [spfl_pkg::SLOT_COUNT-1:0]      written_reg;
    spfl_pkg::link_t                      mem_q_reg;
    spfl_pkg::link_t                      init_q_reg;
    logic                                 hit_q_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
            mem[req.wr_addr] <= req.wr_data;
        if (req.rd_en)
        begin
            mem_q_reg  <= mem[req.rd_addr];
            init_q_reg <= spfl_pkg::init_link(req.rd_addr);
        end
    end

    // Unwritten entries read as the power-up chain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            hit_q_reg   <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
                written_reg[req.wr_addr] <= 1'b1;
            if (req.rd_en)
                hit_q_reg <= written_reg[req.rd_addr];
        end
    end

    assign rd_data = hit_q_reg ? mem_q_reg : init_q_reg;

endmodule

>>> sv/spfl_seq.sv
// Request sequencer: list heads, walk compare, unlink and result words.
`include "assert_macros.svh"

module spfl_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          func,
    input  spfl_pkg::slot_t     slot_number,
    output logic                in_stall,
    input  logic                out_free,
    output spfl_pkg::emit_t     emit,
    output spfl_pkg::ram_req_t  ram_req,
    input  spfl_pkg::link_t     rd_data
);

    spfl_pkg::state_t   state_reg, state_next;
    spfl_pkg::func_t    func_reg, func_next;
    spfl_pkg::slot_t    num_reg, num_next;
    spfl_pkg::link_t    free_head_reg, free_head_next;
    spfl_pkg::link_t    active_head_reg, active_head_next;
    spfl_pkg::cnt_t     count_reg, count_next;
    spfl_pkg::link_t    cur_reg, cur_next;
    spfl_pkg::link_t    prev_reg, prev_next;
    spfl_pkg::cnt_t     steps_reg, steps_next;
    logic               use_head_reg, use_head_next;
    spfl_pkg::slot_t    rpt_id_reg, rpt_id_next;
    spfl_pkg::status_t  rpt_status_reg, rpt_status_next;

    spfl_pkg::link_t    walk_cur;
    logic               walk_null;
    logic               walk_hit;
    logic               walk_limit;
    logic               list_fin;
    logic               free_empty;
    logic               active_empty;

    // First compare uses the head register, later ones the fetched link.
    assign walk_cur     = use_head_reg ? active_head_reg : rd_data;
    assign walk_null    = walk_cur >= spfl_pkg::NULL_LINK;
    assign walk_hit     = !walk_null && (walk_cur[spfl_pkg::SLOT_W-1:0] == num_reg);
    assign walk_limit   = steps_reg == spfl_pkg::FULL_COUNT;
    assign list_fin     = (rd_data >= spfl_pkg::NULL_LINK) || (steps_reg == spfl_pkg::LAST_STEP);
    assign free_empty   = free_head_reg >= spfl_pkg::NULL_LINK;
    assign active_empty = active_head_reg >= spfl_pkg::NULL_LINK;

    assign in_stall = state_reg != spfl_pkg::ST_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= spfl_pkg::ST_IDLE;
            func_reg        <= spfl_pkg::FUNC_ALLOC;
            free_head_reg   <= '0;
            active_head_reg <= spfl_pkg::NULL_LINK;
            count_reg       <= '0;
            steps_reg       <= '0;
            use_head_reg    <= 1'b0;
            prev_reg        <= spfl_pkg::NULL_LINK;
        end
        else
        begin
            state_reg       <= state_next;
            func_reg        <= func_next;
            free_head_reg   <= free_head_next;
            active_head_reg <= active_head_next;
            count_reg       <= count_next;
            steps_reg       <= steps_next;
            use_head_reg    <= use_head_next;
            prev_reg        <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg        <= num_next;
        cur_reg        <= cur_next;
        rpt_id_reg     <= rpt_id_next;
        rpt_status_reg <= rpt_status_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spfl_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = spfl_pkg::ST_DISPATCH;
            end
            spfl_pkg::ST_DISPATCH:
            begin
                unique case (func_reg)
                    spfl_pkg::FUNC_ALLOC:
                        state_next = free_empty ? spfl_pkg::ST_REPORT : spfl_pkg::ST_ALLOC_POP;
                    spfl_pkg::FUNC_FREE:
                        state_next = active_empty ? spfl_pkg::ST_REPORT : spfl_pkg::ST_FREE_WALK;
                    spfl_pkg::FUNC_LIST:
                        state_next = active_empty ? spfl_pkg::ST_REPORT : spfl_pkg::ST_LIST;
                    default:
                        state_next = spfl_pkg::ST_IDLE;
                endcase
            end
            spfl_pkg::ST_REPORT, spfl_pkg::ST_ALLOC_POP, spfl_pkg::ST_FREE_PUSH:
            begin
                if (out_free)
                    state_next = spfl_pkg::ST_IDLE;
            end
            spfl_pkg::ST_FREE_WALK:
            begin
                priority if (walk_null)
                    state_next = spfl_pkg::ST_REPORT;
                else if (walk_hit)
                    state_next = spfl_pkg::ST_FREE_UNLINK;
                else if (walk_limit)
                    state_next = spfl_pkg::ST_REPORT;
            end
            spfl_pkg::ST_FREE_UNLINK:
                state_next = spfl_pkg::ST_FREE_PUSH;
            spfl_pkg::ST_LIST:
            begin
                if (out_free && list_fin)
                    state_next = spfl_pkg::ST_IDLE;
            end
            default:
                state_next = spfl_pkg::ST_IDLE;
        endcase
    end

    // Datapath, link table port and result words
    always_comb
    begin
        func_next        = func_reg;
        num_next         = num_reg;
        free_head_next   = free_head_reg;
        active_head_next = active_head_reg;
        count_next       = count_reg;
        cur_next         = cur_reg;
        prev_next        = prev_reg;
        steps_next       = steps_reg;
        use_head_next    = use_head_reg;
        rpt_id_next      = rpt_id_reg;
        rpt_status_next  = rpt_status_reg;
        emit             = '0;
        ram_req          = '0;

        unique case (state_reg)
            spfl_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    func_next = spfl_pkg::func_t'(func);
                    num_next  = slot_number;
                end
            end
            spfl_pkg::ST_DISPATCH:
            begin
                unique case (func_reg)
                    spfl_pkg::FUNC_ALLOC:
                    begin
                        if (free_empty)
                        begin
                            rpt_id_next     = '0;
                            rpt_status_next = spfl_pkg::STAT_EXHAUSTED;
                        end
                        else
                        begin
                            ram_req.rd_en   = 1'b1;
                            ram_req.rd_addr = free_head_reg[spfl_pkg::SLOT_W-1:0];
                        end
                    end
                    spfl_pkg::FUNC_FREE:
                    begin
                        rpt_id_next     = num_reg;
                        rpt_status_next = spfl_pkg::STAT_EMPTY;
                        use_head_next   = 1'b1;
                        steps_next      = '0;
                        prev_next       = spfl_pkg::NULL_LINK;
                    end
                    spfl_pkg::FUNC_LIST:
                    begin
                        if (active_empty)
                        begin
                            rpt_id_next     = '0;
                            rpt_status_next = spfl_pkg::STAT_EMPTY;
                        end
                        else
                        begin
                            cur_next        = active_head_reg;
                            steps_next      = '0;
                            ram_req.rd_en   = 1'b1;
                            ram_req.rd_addr = active_head_reg[spfl_pkg::SLOT_W-1:0];
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            spfl_pkg::ST_REPORT:
            begin
                if (out_free)
                begin
                    emit.valid   = 1'b1;
                    emit.slot_id = rpt_id_reg;
                    emit.status  = rpt_status_reg;
                    emit.last    = 1'b1;
                end
            end
            spfl_pkg::ST_ALLOC_POP:
            begin
                if (out_free)
                begin
                    free_head_next   = rd_data;
                    active_head_next = free_head_reg;
                    count_next       = count_reg + spfl_pkg::cnt_t'(1);
                    ram_req.wr_en    = 1'b1;
                    ram_req.wr_addr  = free_head_reg[spfl_pkg::SLOT_W-1:0];
                    ram_req.wr_data  = active_head_reg;
                    emit.valid       = 1'b1;
                    emit.slot_id     = free_head_reg[spfl_pkg::SLOT_W-1:0];
                    emit.status      = spfl_pkg::STAT_OK;
                    emit.last        = 1'b1;
                end
            end
            spfl_pkg::ST_FREE_WALK:
            begin
                rpt_id_next     = num_reg;
                rpt_status_next = spfl_pkg::STAT_NOT_ACTIVE;
                priority if (walk_null)
                begin
                end
                else if (walk_hit)
                begin
                    cur_next        = walk_cur;
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = walk_cur[spfl_pkg::SLOT_W-1:0];
                end
                else if (walk_limit)
                begin
                end
                else
                begin
                    prev_next       = walk_cur;
                    steps_next      = steps_reg + spfl_pkg::cnt_t'(1);
                    use_head_next   = 1'b0;
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = walk_cur[spfl_pkg::SLOT_W-1:0];
                end
            end
            spfl_pkg::ST_FREE_UNLINK:
            begin
                // rd_data is the successor of the slot being released
                if (prev_reg >= spfl_pkg::NULL_LINK)
                    active_head_next = rd_data;
                else
                begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = prev_reg[spfl_pkg::SLOT_W-1:0];
                    ram_req.wr_data = rd_data;
                end
            end
            spfl_pkg::ST_FREE_PUSH:
            begin
                if (out_free)
                begin
                    free_head_next  = cur_reg;
                    count_next      = count_reg - spfl_pkg::cnt_t'(1);
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = cur_reg[spfl_pkg::SLOT_W-1:0];
                    ram_req.wr_data = free_head_reg;
                    emit.valid      = 1'b1;
                    emit.slot_id    = num_reg;
                    emit.status     = spfl_pkg::STAT_OK;
                    emit.last       = 1'b1;
                end
            end
            spfl_pkg::ST_LIST:
            begin
                if (out_free)
                begin
                    emit.valid   = 1'b1;
                    emit.slot_id = cur_reg[spfl_pkg::SLOT_W-1:0];
                    emit.status  = spfl_pkg::STAT_OK;
                    emit.last    = list_fin;
                    if (!list_fin)
                    begin
                        cur_next        = rd_data;
                        steps_next      = steps_reg + spfl_pkg::cnt_t'(1);
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = rd_data[spfl_pkg::SLOT_W-1:0];
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    `ASSERT_CLK(a_exhausted_full, clk, rst_n, free_empty |-> (count_reg == spfl_pkg::FULL_COUNT), "free list empty but active count not full")
    `ASSERT_CLK(a_emit_room, clk, rst_n, emit.valid |-> out_free, "result word issued while output register is held")
    `ASSERT_CLK(a_list_cur, clk, rst_n, (state_reg == spfl_pkg::ST_LIST) |-> (cur_reg < spfl_pkg::NULL_LINK), "list walk holds a null slot")

endmodule
